// File: rtl/nca_pkg.sv
// ----------------------------------------------------------------------------
// nca_pkg
// shared types and constants for the nearest centroid assignment block
// ----------------------------------------------------------------------------
package nca_pkg;

    localparam int COORD_W = 17;
    localparam int IDX_OUT_W = 3;
    localparam int SQ_W = 2 * COORD_W;
    localparam int DIST_W = SQ_W + 1;

    localparam logic NCA_CMD_APPEND = 1'b0;
    localparam logic NCA_CMD_CLASSIFY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
    } nca_in_t;

    typedef struct packed {
        logic                 found;
        logic [IDX_OUT_W-1:0] nearest_index;
        logic [DIST_W-1:0]    nearest_dist_sq;
        logic [COORD_W-1:0]   point_x;
        logic [COORD_W-1:0]   point_y;
    } nca_out_t;

endpackage

// File: rtl/nearest_centroid_assign_top.sv
// ----------------------------------------------------------------------------
// nearest_centroid_assign_top
// k-means assignment step: stores centroids and labels points with the nearest
// ----------------------------------------------------------------------------
// an append beat is only a table write in the back part; a classify beat
// leaving the queue runs through the single distance pipeline, one centroid a
// cycle over the n stored centroids, n being the fill count tagged on the beat,
// then its result is registered, straight away if n is 0; the back part takes
// no new op until that result loads, which waits while a result is not popped
// rst_n clears the table fill count, queue and result register; table contents
// are left as they are and are only read below the fill count
// ----------------------------------------------------------------------------
module nearest_centroid_assign_top
    import nca_pkg::*;
#(
    parameter int MAX_CENTROIDS = 8
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  nca_in_t  item,
    output logic     full,
    input  logic     pop,
    output logic     empty,
    output nca_out_t result
);

    // fill count must hold the capacity itself
    localparam int CNT_W = $clog2(MAX_CENTROIDS + 1);
    localparam int IDX_W = (MAX_CENTROIDS > 1) ? $clog2(MAX_CENTROIDS) : 1;
    localparam int OP_W  = CNT_W + $bits(nca_in_t);

    // front to queue
    logic             f_wr;
    logic [CNT_W-1:0] f_cnt;
    nca_in_t          f_item;
    logic             q_full;

    // queue to back
    logic             q_empty;
    logic             q_rd;
    logic [OP_W-1:0]  q_data;
    logic [CNT_W-1:0] b_cnt;
    nca_in_t          b_item;

    assign b_cnt  = q_data[OP_W-1 -: CNT_W];
    assign b_item = nca_in_t'(q_data[$bits(nca_in_t)-1:0]);

    // front: takes beats, drops appends once the table is full,
    // tags each op with the fill count seen at accept time
    nca_front #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .CNT_W         (CNT_W)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .item   (item),
        .full   (full),
        .q_wr   (f_wr),
        .q_cnt  (f_cnt),
        .q_item (f_item),
        .q_full (q_full)
    );

    // short op queue so the front keeps taking beats while the back sweeps
    nca_queue #(
        .WIDTH (OP_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (f_wr),
        .wr_data ({f_cnt, f_item}),
        .full    (q_full),
        .rd      (q_rd),
        .rd_data (q_data),
        .empty   (q_empty)
    );

    // back: table writes, distance sweep and result register
    nca_back #(
        .MAX_CENTROIDS (MAX_CENTROIDS),
        .CNT_W         (CNT_W),
        .IDX_W         (IDX_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_cnt   (b_cnt),
        .q_item  (b_item),
        .q_rd    (q_rd),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// File: rtl/nca_queue.sv
// ----------------------------------------------------------------------------
// nca_queue
// two-entry first-in first-out buffer between the front and back parts
// ----------------------------------------------------------------------------
module nca_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       fill_reg;
    logic [1:0]       fill_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (fill_reg == 2'd2);
    assign empty   = (fill_reg == 2'd0);
    assign rd_data = entry_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/nca_front.sv
// ----------------------------------------------------------------------------
// nca_front
// accepts input beats, tracks table fill and tags each op with its slot count
// ----------------------------------------------------------------------------
module nca_front
    import nca_pkg::*;
#(
    parameter int MAX_CENTROIDS = 8,
    parameter int CNT_W = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  nca_in_t          item,
    output logic             full,
    output logic             q_wr,
    output logic [CNT_W-1:0] q_cnt,
    output nca_in_t          q_item,
    input  logic             q_full
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             accept;
    logic             is_append;
    logic             table_full;

    assign full       = q_full;
    assign accept     = push && !q_full;
    assign is_append  = (item.cmd == NCA_CMD_APPEND);
    assign table_full = (count_reg == CNT_W'(MAX_CENTROIDS));

    // appends to a full table are dropped here
    assign q_wr   = accept && !(is_append && table_full);
    assign q_cnt  = count_reg;
    assign q_item = item;

    always_comb
    begin
        count_next = count_reg;
        if (q_wr && is_append)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/nca_back.sv
// ----------------------------------------------------------------------------
// nca_back
// centroid table, pipelined distance sweep, running minimum and result register
// ----------------------------------------------------------------------------
module nca_back
    import nca_pkg::*;
#(
    parameter int MAX_CENTROIDS = 8,
    parameter int CNT_W = 4,
    parameter int IDX_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  logic [CNT_W-1:0] q_cnt,
    input  nca_in_t          q_item,
    output logic             q_rd,
    output logic             empty,
    input  logic             pop,
    output nca_out_t         result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [COORD_W-1:0] mem_x [MAX_CENTROIDS];
    logic [COORD_W-1:0] mem_y [MAX_CENTROIDS];

    logic [1:0]         st_reg;
    logic [1:0]         st_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   iss_reg;
    logic [CNT_W-1:0]   iss_next;
    logic [COORD_W-1:0] px_reg;
    logic [COORD_W-1:0] py_reg;

    logic               v1_reg;
    logic               l1_reg;
    logic [IDX_W-1:0]   i1_reg;
    logic [COORD_W-1:0] cx_reg;
    logic [COORD_W-1:0] cy_reg;
    logic               v2_reg;
    logic               l2_reg;
    logic [IDX_W-1:0]   i2_reg;
    logic [COORD_W-1:0] dx_reg;
    logic [COORD_W-1:0] dy_reg;
    logic               v3_reg;
    logic               l3_reg;
    logic [IDX_W-1:0]   i3_reg;
    logic [SQ_W-1:0]    sqx_reg;
    logic [SQ_W-1:0]    sqy_reg;

    logic               best_have_reg;
    logic               best_have_next;
    logic [DIST_W-1:0]  best_d_reg;
    logic [DIST_W-1:0]  best_d_next;
    logic [IDX_W-1:0]   best_i_reg;
    logic [IDX_W-1:0]   best_i_next;

    logic               res_valid_reg;
    logic               res_valid_next;
    nca_out_t           res_reg;

    logic               op_take;
    logic               op_classify;
    logic               wr_en;
    logic               v0;
    logic               l0;
    logic               res_load;
    logic [DIST_W-1:0]  d_sum;

    assign op_take     = (st_reg == ST_IDLE) && !q_empty;
    assign op_classify = (q_item.cmd == NCA_CMD_CLASSIFY);
    assign q_rd        = op_take;
    assign wr_en       = op_take && !op_classify;
    assign v0          = (st_reg == ST_RUN) && (iss_reg < n_reg);
    assign l0          = ((iss_reg + CNT_W'(1)) == n_reg);
    assign res_load    = (st_reg == ST_DONE) && (!res_valid_reg || pop);
    assign d_sum       = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    always_comb
    begin
        st_next        = st_reg;
        iss_next       = iss_reg;
        best_have_next = best_have_reg;
        best_d_next    = best_d_reg;
        best_i_next    = best_i_reg;
        res_valid_next = res_valid_reg;

        if (pop && res_valid_reg)
        begin
            res_valid_next = 1'b0;
        end

        // running minimum, earliest index kept on ties
        if (v3_reg && (!best_have_reg || (d_sum < best_d_reg)))
        begin
            best_have_next = 1'b1;
            best_d_next    = d_sum;
            best_i_next    = i3_reg;
        end

        unique case (st_reg)
            ST_IDLE:
            begin
                if (op_take && op_classify)
                begin
                    iss_next       = '0;
                    best_have_next = 1'b0;
                    st_next        = (q_cnt == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (v0)
                begin
                    iss_next = iss_reg + CNT_W'(1);
                end
                if (v3_reg && l3_reg)
                begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (res_load)
                begin
                    res_valid_next = 1'b1;
                    st_next        = ST_IDLE;
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            iss_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            best_have_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            iss_reg       <= iss_next;
            v1_reg        <= v0;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            best_have_reg <= best_have_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // centroid table, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_x[q_cnt[IDX_W-1:0]] <= q_item.coord_x;
            mem_y[q_cnt[IDX_W-1:0]] <= q_item.coord_y;
        end
        if (v0)
        begin
            cx_reg <= mem_x[iss_reg[IDX_W-1:0]];
            cy_reg <= mem_y[iss_reg[IDX_W-1:0]];
        end
    end

    // payload path
    always_ff @(posedge clk)
    begin
        if (op_take && op_classify)
        begin
            n_reg  <= q_cnt;
            px_reg <= q_item.coord_x;
            py_reg <= q_item.coord_y;
        end
        l1_reg  <= l0;
        i1_reg  <= iss_reg[IDX_W-1:0];
        l2_reg  <= l1_reg;
        i2_reg  <= i1_reg;
        dx_reg  <= (px_reg >= cx_reg) ? (px_reg - cx_reg) : (cx_reg - px_reg);
        dy_reg  <= (py_reg >= cy_reg) ? (py_reg - cy_reg) : (cy_reg - py_reg);
        l3_reg  <= l2_reg;
        i3_reg  <= i2_reg;
        sqx_reg <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        if (res_load)
        begin
            res_reg.found           <= best_have_reg;
            res_reg.nearest_index   <= best_have_reg ? IDX_OUT_W'(best_i_reg) : '0;
            res_reg.nearest_dist_sq <= best_have_reg ? best_d_reg : '0;
            res_reg.point_x         <= px_reg;
            res_reg.point_y         <= py_reg;
        end
    end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the nearest centroid assignment block: a scoreboard
// keeps its own centroid table, predicts each classify beat and checks every
// result beat in order, under three mixes of idling on both queue sides
// ----------------------------------------------------------------------------
module tb_top
    import nca_pkg::*;
();

    localparam int NUM_SLOTS   = 8;
    localparam int COORD_MAX   = (1 << COORD_W) - 1;
    // classify beats per random phase, three phases in all
    localparam int PHASE_ITEMS = 285;
    // settling time at the end of the run, after all predicted results are popped
    localparam int END_SETTLE  = 40;
    // cycles without any handshake before the run is declared hung; the longest
    // correct gap is a receiver stall at 86 percent idling, far below this
    localparam int STALL_LIMIT = 2000;
    localparam int SHOW_MAX    = 10;

    // ------------------------------------------------------------------------
    // scoreboard: own copy of the centroid table and the queue of predicted
    // result beats, oldest first
    // ------------------------------------------------------------------------
    class centroid_scoreboard;
        logic [COORD_W-1:0] cent_x [NUM_SLOTS];
        logic [COORD_W-1:0] cent_y [NUM_SLOTS];
        int unsigned        fill;
        nca_out_t           expected_q [$];
        int unsigned        errors;
        int unsigned        appends;
        int unsigned        dropped;
        int unsigned        classifies;
        int unsigned        checked;

        function new();
            fill       = 0;
            errors     = 0;
            appends    = 0;
            dropped    = 0;
            classifies = 0;
            checked    = 0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function string describe(nca_out_t r);
            return $sformatf("found=%0d idx=%0d dist=%0d x=%0d y=%0d", r.found,
                             r.nearest_index, r.nearest_dist_sq, r.point_x, r.point_y);
        endfunction

        // accepted input beat: update the table or predict the classify result
        function void note_input(nca_in_t beat);
            nca_out_t    want;
            bit [63:0]   dx;
            bit [63:0]   dy;
            bit [63:0]   d;
            bit [63:0]   best;
            int unsigned i;
            if (beat.cmd == NCA_CMD_APPEND)
            begin
                appends++;
                // table full: the append is dropped
                if (fill < NUM_SLOTS)
                begin
                    cent_x[fill] = beat.coord_x;
                    cent_y[fill] = beat.coord_y;
                    fill++;
                end
                else
                begin
                    dropped++;
                end
                return;
            end
            classifies++;
            want         = '0;
            best         = '0;
            want.point_x = beat.coord_x;
            want.point_y = beat.coord_y;
            for (i = 0; i < fill; i++)
            begin
                dx = (beat.coord_x >= cent_x[i]) ? beat.coord_x - cent_x[i]
                                                 : cent_x[i] - beat.coord_x;
                dy = (beat.coord_y >= cent_y[i]) ? beat.coord_y - cent_y[i]
                                                 : cent_y[i] - beat.coord_y;
                d  = dx * dx + dy * dy;
                // strict less-than keeps the earliest centroid on a tie
                if (!want.found || d < best)
                begin
                    best               = d;
                    want.nearest_index = IDX_OUT_W'(i);
                    want.found         = 1'b1;
                end
            end
            want.nearest_dist_sq = DIST_W'(best);
            expected_q.insert(expected_q.size(), want);
        endfunction

        // accepted result beat: compare field by field with the oldest prediction
        function void check_result(nca_out_t got);
            nca_out_t want;
            string    bad;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("[%0t] result beat with nothing expected: %s", $time,
                             describe(got));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            bad  = "";
            if (got.found !== want.found)                     bad = {bad, " found"};
            if (got.nearest_index !== want.nearest_index)     bad = {bad, " nearest_index"};
            if (got.nearest_dist_sq !== want.nearest_dist_sq) bad = {bad, " nearest_dist_sq"};
            if (got.point_x !== want.point_x)                 bad = {bad, " point_x"};
            if (got.point_y !== want.point_y)                 bad = {bad, " point_y"};
            if (bad != "")
            begin
                errors++;
                if (errors <= SHOW_MAX)
                    $display("[%0t] mismatch in%s: expected %s, got %s", $time, bad,
                             describe(want), describe(got));
            end
        endfunction
    endclass

    logic     clk;
    logic     rst_n;
    logic     push;
    nca_in_t  item;
    logic     full;
    logic     pop;
    logic     empty;
    nca_out_t result;

    centroid_scoreboard sb = new();

    // idling percentages, changed only by the main sequence
    int send_idle_pct = 0;
    int recv_idle_pct = 100;
    int stall_cycles  = 0;

    nearest_centroid_assign_top #(
        .MAX_CENTROIDS(NUM_SLOTS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (item),
        .full  (full),
        .pop   (pop),
        .empty (empty),
        .result(result)
    );

    // 8 ns clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver side: pop decided at each falling edge from the current idling mix
    initial
    begin
        pop = 1'b0;
        forever
        begin
            @(negedge clk);
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // both handshakes sampled at the rising edge, plus the hang watchdog
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            sb.note_input(item);
        if (rst_n && pop && !empty)
            sb.check_result(result);
        if ((push && !full) || (pop && !empty))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int unsigned clamp_coord(int v);
        if (v < 0)
            return 0;
        if (v > COORD_MAX)
            return COORD_MAX;
        return v;
    endfunction

    // one input beat: random sender gaps first, then hold push until accepted
    task automatic send_item(logic cmd, int unsigned x, int unsigned y);
        nca_in_t beat;
        beat.cmd     = cmd;
        beat.coord_x = COORD_W'(x);
        beat.coord_y = COORD_W'(y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // sender holds off until every predicted result has been popped
    task automatic wait_for_results();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int send_pcts [3];
        int recv_pcts [3];
        int phase;
        int phase_classifies;
        int mode;
        int a;
        int b;
        int unsigned px;
        int unsigned py;

        send_pcts = '{17, 86, 0};
        recv_pcts = '{86, 17, 0};

        rst_n = 1'b0;
        push  = 1'b0;
        item  = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // --------------------------------------------------------------------
        // directed part: empty table, extremes, ties, full table
        // --------------------------------------------------------------------
        send_idle_pct = 0;
        recv_idle_pct = 30;

        // empty table: found low, point still passed through
        send_item(NCA_CMD_CLASSIFY, 0, 0);
        send_item(NCA_CMD_CLASSIFY, COORD_MAX, COORD_MAX);

        // single centroid at the origin: largest possible distance, then zero
        send_item(NCA_CMD_APPEND, 0, 0);
        send_item(NCA_CMD_CLASSIFY, COORD_MAX, COORD_MAX);
        send_item(NCA_CMD_CLASSIFY, 0, 0);

        // opposite corner; points near the midpoint, one of them an exact tie, earliest wins
        send_item(NCA_CMD_APPEND, COORD_MAX, COORD_MAX);
        send_item(NCA_CMD_CLASSIFY, 65535, 65535);
        send_item(NCA_CMD_CLASSIFY, 65536, 65535);
        send_item(NCA_CMD_CLASSIFY, COORD_MAX, COORD_MAX);

        // two centroids equally far from the point
        send_item(NCA_CMD_APPEND, 1000, 2000);
        send_item(NCA_CMD_APPEND, 3000, 2000);
        send_item(NCA_CMD_CLASSIFY, 2000, 2000);

        // fill the table, one entry duplicating an earlier one
        send_item(NCA_CMD_APPEND, 0, COORD_MAX);
        send_item(NCA_CMD_APPEND, COORD_MAX, 0);
        send_item(NCA_CMD_APPEND, 1000, 2000);
        send_item(NCA_CMD_APPEND, 70000, 60000);
        send_item(NCA_CMD_CLASSIFY, 1000, 2000);

        // table full: these appends are dropped
        send_item(NCA_CMD_APPEND, 5, 5);
        send_item(NCA_CMD_APPEND, COORD_MAX, COORD_MAX);
        send_item(NCA_CMD_CLASSIFY, 5, 5);
        send_item(NCA_CMD_CLASSIFY, COORD_MAX, 0);
        send_item(NCA_CMD_CLASSIFY, 70001, 59999);
        send_item(NCA_CMD_CLASSIFY, 0, COORD_MAX);

        // --------------------------------------------------------------------
        // random part: three idling mixes, drained between phases
        // --------------------------------------------------------------------
        for (phase = 0; phase < 3; phase++)
        begin
            wait_for_results();
            send_idle_pct    = send_pcts[phase];
            recv_idle_pct    = recv_pcts[phase];
            phase_classifies = 0;
            while (phase_classifies < PHASE_ITEMS)
            begin
                if ($urandom_range(99) < 8)
                begin
                    // noise: appends against the full table
                    send_item(NCA_CMD_APPEND, $urandom_range(0, COORD_MAX),
                              $urandom_range(0, COORD_MAX));
                end
                else
                begin
                    mode = $urandom_range(0, 9);
                    px   = $urandom_range(0, COORD_MAX);
                    py   = $urandom_range(0, COORD_MAX);
                    if (sb.fill != 0)
                    begin
                        a = $urandom_range(0, sb.fill - 1);
                        b = $urandom_range(0, sb.fill - 1);
                        if (mode >= 4 && mode <= 6)
                        begin
                            // close to one centroid
                            px = clamp_coord(int'(sb.cent_x[a]) +
                                             int'($urandom_range(0, 64)) - 32);
                            py = clamp_coord(int'(sb.cent_y[a]) +
                                             int'($urandom_range(0, 64)) - 32);
                        end
                        else if (mode == 7)
                        begin
                            // corners and edges of the coordinate range
                            px = $urandom_range(0, 1) ? COORD_MAX : 0;
                            py = $urandom_range(0, 1) ? COORD_MAX : 0;
                        end
                        else if (mode == 8)
                        begin
                            // halfway between two centroids, often a tie
                            px = (int'(sb.cent_x[a]) + int'(sb.cent_x[b])) / 2;
                            py = (int'(sb.cent_y[a]) + int'(sb.cent_y[b])) / 2;
                        end
                        else if (mode == 9)
                        begin
                            px = 32'(sb.cent_x[a]);
                            py = 32'(sb.cent_y[a]);
                        end
                    end
                    send_item(NCA_CMD_CLASSIFY, px, py);
                    phase_classifies++;
                end
                // occasional hold-off until the result queue is drained
                if ($urandom_range(199) == 0)
                    wait_for_results();
            end
        end

        // --------------------------------------------------------------------
        // end of run: drain, settle, report
        // --------------------------------------------------------------------
        wait_for_results();
        repeat (END_SETTLE) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $display("%0d predicted results never arrived", sb.pending());
            sb.errors += sb.pending();
        end

        $display("covered %0d classify and %0d append beats (%0d dropped on a full table)",
                 sb.classifies, sb.appends, sb.dropped);
        $display("%0d result beats checked over three idling mixes, %0d errors",
                 sb.checked, sb.errors);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
